### rtl/entropy_mixing_random_source_macros.svh
// assertion macros for the entropy mixing random source checker
`ifndef ENTROPY_MIXING_RANDOM_SOURCE_MACROS_SVH
`define ENTROPY_MIXING_RANDOM_SOURCE_MACROS_SVH
// implication checked on every clock edge outside reset
`define EMRS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication checked outside reset
`define EMRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### rtl/emrs_pkg.sv
// package for the entropy mixing random source: constants and width helpers
`timescale 1ns / 1ps
package emrs_pkg;
	localparam int unsigned WORD_W = 64;
	localparam int unsigned MULT_W = 32;
	localparam logic [63:0] ENTROPY_RESET = 64'hDEADBEEFDEADBEEF;
	localparam logic [63:0] MIX_MUL_A = 64'h00000FAC1FFFFEEE;
	localparam logic [63:0] MIX_MUL_B = 64'h000000FFFEEAD234;
	localparam logic [63:0] SIGNED64_SEED = 64'd12945845;
	localparam logic [31:0] SHUFFLE_RESET = 32'd1;
	localparam logic [1:0] WS_8 = 2'd0;
	localparam logic [1:0] WS_16 = 2'd1;
	localparam logic [1:0] WS_32 = 2'd2;
	localparam logic [1:0] WS_64 = 2'd3;

	function automatic logic [63:0] width_mask(input logic [1:0] ws);
		logic [63:0] m;
		unique case (ws)
			WS_8: m = 64'h00000000000000FF;
			WS_16: m = 64'h000000000000FFFF;
			WS_32: m = 64'h00000000FFFFFFFF;
			default: m = 64'hFFFFFFFFFFFFFFFF;
		endcase
		return m;
	endfunction

	function automatic logic [63:0] sign_bit(input logic [1:0] ws);
		logic [63:0] s;
		s = (width_mask(ws) >> 1) + 64'd1;
		return s;
	endfunction
endpackage

### rtl/entropy_mixing_random_source.sv
// entropy mixing random source: bit-serial multiply and modulo sequencer
// one beat in flight at a time; the next beat is accepted the cycle after the result is
// posted; each 64-bit multiply runs in a shift-and-add unit and each modulo runs
// as a restoring division; a ranged draw with a valid range adds a modulo, and a signed
// 64-bit draw of nonzero value adds a modulo and a multiply ahead of the mixing chain
// reset: async active low, entropy word to 0xDEADBEEFDEADBEEF, multiplier to 1
`timescale 1ns / 1ps
module entropy_mixing_random_source
	import emrs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [1:0]  width_select,
	input  logic        signed_mode,
	input  logic [63:0] range_low,
	input  logic [63:0] range_high,
	input  logic [63:0] time_ms,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] value,
	output logic        range_error
);
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SMOD  = 4'd1;
	localparam logic [3:0] ST_SMUL  = 4'd2;
	localparam logic [3:0] ST_MULA  = 4'd3;
	localparam logic [3:0] ST_XADD  = 4'd4;
	localparam logic [3:0] ST_MULB  = 4'd5;
	localparam logic [3:0] ST_XSH   = 4'd6;
	localparam logic [3:0] ST_MULC  = 4'd7;
	localparam logic [3:0] ST_RANGE = 4'd8;
	localparam logic [3:0] ST_RMOD  = 4'd9;
	localparam logic [3:0] ST_DONE  = 4'd10;
	localparam logic [3:0] ST_OUT   = 4'd11;
	localparam logic [3:0] ST_PMUL  = 4'd12;
	localparam logic [3:0] ST_SETA  = 4'd13;

	logic [3:0]  state_q;
	logic [63:0] ent_q;
	logic [31:0] shuf_q;
	logic        act_q, sgn_q;
	logic [1:0]  ws_q;
	logic [63:0] lo_q, hi_q, tm_q, draw_q;
	logic [63:0] res_q;
	logic        rerr_q;
	logic [63:0] value_q;
	logic        err_q;
	logic        ovalid_q;
	// serial unit: multiplier (a x b) or divider (rem of a by b)
	logic [63:0] a_q, b_q, acc_q;
	logic [5:0]  cnt_q;

	logic [63:0] m, sb, draw_w, mag_w, diff_w, rem_sh, acc_add;
	logic        above_w;

	always_comb begin
		m = width_mask(ws_q);
		sb = sign_bit(ws_q);
		draw_w = ent_q & width_mask(width_select);
		mag_w = draw_q;
		if (sgn_q && ((draw_q & sb) != 64'd0)) mag_w = (64'd0 - draw_q) & m;
		if (sgn_q) above_w = (hi_q ^ sb) > (lo_q ^ sb);
		else above_w = hi_q > lo_q;
		diff_w = (hi_q - lo_q) & m;
		rem_sh = {acc_q[62:0], a_q[63]};
		acc_add = acc_q + (a_q[0] ? b_q : 64'd0);
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = ovalid_q;
	assign value = value_q;
	assign range_error = err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ent_q <= ENTROPY_RESET;
			shuf_q <= SHUFFLE_RESET;
			act_q <= 1'b0;
			sgn_q <= 1'b0;
			ws_q <= WS_8;
			lo_q <= '0;
			hi_q <= '0;
			tm_q <= '0;
			draw_q <= '0;
			res_q <= '0;
			rerr_q <= 1'b0;
			value_q <= '0;
			err_q <= 1'b0;
			ovalid_q <= 1'b0;
			a_q <= '0;
			b_q <= '0;
			acc_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cfg_we) shuf_q <= cfg_wdata;
			if (state_q == ST_DONE && (!ovalid_q || out_ready)) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						act_q <= action;
						ws_q <= width_select;
						sgn_q <= signed_mode;
						lo_q <= range_low & width_mask(width_select);
						hi_q <= range_high & width_mask(width_select);
						tm_q <= time_ms;
						draw_q <= draw_w;
						cnt_q <= '0;
						if (signed_mode && width_select == WS_64 && draw_w != 64'd0) begin
							a_q <= SIGNED64_SEED;
							b_q <= draw_w[63] ? (64'd0 - draw_w) : draw_w;
							acc_q <= '0;
							state_q <= ST_SMOD;
						end else begin
							a_q <= ent_q;
							b_q <= MIX_MUL_A;
							acc_q <= '0;
							state_q <= ST_MULA;
						end
					end
				end
				ST_SMOD, ST_RMOD: begin
					// restoring remainder, one quotient bit a cycle
					a_q <= {a_q[62:0], 1'b0};
					if ({acc_q[63], rem_sh} >= {1'b0, b_q}) acc_q <= rem_sh - b_q;
					else acc_q <= rem_sh;
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63)
						state_q <= (state_q == ST_SMOD) ? ST_SMUL : ST_DONE;
				end
				ST_SMUL: begin
					a_q <= ent_q;
					b_q <= acc_q;
					acc_q <= '0;
					cnt_q <= '0;
					state_q <= ST_PMUL;
				end
				ST_PMUL, ST_MULA, ST_MULB, ST_MULC: begin
					acc_q <= acc_add;
					a_q <= {1'b0, a_q[63:1]};
					b_q <= {b_q[62:0], 1'b0};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						unique case (state_q)
							ST_PMUL: state_q <= ST_SETA;
							ST_MULA: state_q <= ST_XADD;
							ST_MULB: state_q <= ST_XSH;
							default: state_q <= ST_RANGE;
						endcase
					end
				end
				ST_SETA: begin
					a_q <= acc_q;
					b_q <= MIX_MUL_A;
					acc_q <= '0;
					state_q <= ST_MULA;
				end
				ST_XADD: begin
					a_q <= (acc_q ^ (acc_q << 24)) + tm_q;
					b_q <= MIX_MUL_B;
					acc_q <= '0;
					state_q <= ST_MULB;
				end
				ST_XSH: begin
					a_q <= acc_q ^ (acc_q >> 31);
					b_q <= {32'd0, shuf_q};
					acc_q <= '0;
					state_q <= ST_MULC;
				end
				ST_RANGE: begin
					ent_q <= acc_q;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!act_q) begin
						res_q <= draw_q;
						rerr_q <= 1'b0;
						state_q <= ST_DONE;
					end else if (!above_w) begin
						res_q <= lo_q;
						rerr_q <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						a_q <= mag_w;
						b_q <= diff_w;
						acc_q <= '0;
						cnt_q <= '0;
						rerr_q <= 1'b0;
						state_q <= ST_RMOD;
					end
				end
				ST_DONE: begin
					if (!ovalid_q || out_ready) begin
						value_q <= (act_q && !rerr_q) ? ((lo_q + acc_q) & m) : res_q;
						err_q <= rerr_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### rtl/emrs_checker.sv
// port-level checker for the entropy mixing random source
`timescale 1ns / 1ps
`include "entropy_mixing_random_source_macros.svh"
module emrs_checker
	import emrs_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] value
);
	`EMRS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(value), "result beat dropped while stalled")
	`EMRS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready,
		!in_ready, "second beat taken while busy")
	`EMRS_ASSERT_NEXT(a_no_out_on_accept, clk, arst_n, in_valid && in_ready,
		!$rose(out_valid), "result appeared right after accept")
endmodule

bind entropy_mixing_random_source emrs_checker u_emrs_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .value(value)
);

### tb/sv/tb_entropy_mixing_random_source.sv
// testbench for the entropy mixing random source: draws checked against a local predictor
`timescale 1ns / 1ps
module tb_entropy_mixing_random_source;
	import emrs_pkg::*;

	typedef struct packed {
		logic        action;
		logic [1:0]  width_select;
		logic        signed_mode;
		logic [63:0] range_low;
		logic [63:0] range_high;
		logic [63:0] time_ms;
	} draw_req_t;

	typedef struct packed {
		logic [63:0] value;
		logic        range_error;
	} draw_res_t;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 600;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        action = 1'b0;
	logic [1:0]  width_select = '0;
	logic        signed_mode = 1'b0;
	logic [63:0] range_low = '0;
	logic [63:0] range_high = '0;
	logic [63:0] time_ms = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] value;
	logic        range_error;

	draw_req_t   pending_reqs[$];
	draw_res_t   expected_draws[$];
	logic [63:0] entropy_model;
	logic [31:0] shuffle_model;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          errors = 0;
	int          sent = 0;
	int          received = 0;
	int          quiet_cycles = 0;

	always #10 clk = ~clk;

	entropy_mixing_random_source dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .action(action),
		.width_select(width_select), .signed_mode(signed_mode),
		.range_low(range_low), .range_high(range_high), .time_ms(time_ms),
		.out_valid(out_valid), .out_ready(out_ready), .value(value),
		.range_error(range_error)
	);

	function automatic logic [63:0] draw_mask(input logic [1:0] ws);
		case (ws)
			WS_8: return 64'hFF;
			WS_16: return 64'hFFFF;
			WS_32: return 64'hFFFF_FFFF;
			default: return '1;
		endcase
	endfunction

	function automatic draw_res_t predict_draw(input draw_req_t r);
		logic [63:0] m, sb, lo, hi, d, mag, e, diff;
		logic        above;
		draw_res_t   res;
		m = draw_mask(r.width_select);
		sb = (m >> 1) + 64'd1;
		lo = r.range_low & m;
		hi = r.range_high & m;
		d = entropy_model & m;
		res.range_error = 1'b0;
		if (r.signed_mode && r.width_select == WS_64 && d != 0) begin
			mag = (d & sb) != 0 ? -d : d;
			entropy_model = entropy_model * (SIGNED64_SEED % mag);
		end
		e = entropy_model * MIX_MUL_A;
		e = e ^ (e << 24);
		e = e + r.time_ms;
		e = e * MIX_MUL_B;
		e = e ^ (e >> 31);
		entropy_model = e * {32'd0, shuffle_model};
		if (!r.action) begin
			res.value = d;
		end else begin
			above = r.signed_mode ? ((hi ^ sb) > (lo ^ sb)) : (hi > lo);
			if (!above) begin
				res.value = lo;
				res.range_error = 1'b1;
			end else begin
				diff = (hi - lo) & m;
				mag = d;
				if (r.signed_mode && (d & sb) != 0)
					mag = (-d) & m;
				res.value = (lo + (mag % diff)) & m;
			end
		end
		res.value = res.value & m;
		return res;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] edge_val();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return 64'h80 << (8 * $urandom_range(0, 7));
			3: return 64'h7F << (8 * $urandom_range(0, 7));
			4: return {56'd0, 8'($urandom)};
			default: return rand64();
		endcase
	endfunction

	task automatic queue_req(input logic a, input logic [1:0] ws, input logic s,
			input logic [63:0] lo, input logic [63:0] hi, input logic [63:0] t);
		draw_req_t r;
		r = '{a, ws, s, lo, hi, t};
		pending_reqs.push_back(r);
	endtask

	task automatic wait_idle();
		while (pending_reqs.size() != 0 || in_valid || expected_draws.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_shuffle(input logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		shuffle_model = v;
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_draws.push_back(predict_draw({action, width_select, signed_mode,
					range_low, range_high, time_ms}));
				sent++;
			end
			if (!in_valid || in_ready) begin
				if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					draw_req_t r;
					r = pending_reqs.pop_front();
					in_valid <= 1'b1;
					{action, width_select, signed_mode, range_low, range_high, time_ms} <= r;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (out_valid && out_ready) begin
				received++;
				if (expected_draws.size() == 0) begin
					$display("%0t: unexpected beat value=%h err=%b", $time, value, range_error);
					errors++;
				end else begin
					draw_res_t x;
					x = expected_draws.pop_front();
					if (x.value !== value) begin
						$display("%0t: value expected %h actual %h", $time, x.value, value);
						errors++;
					end
					if (x.range_error !== range_error) begin
						$display("%0t: range_error expected %b actual %b", $time,
							x.range_error, range_error);
						errors++;
					end
				end
			end
			if (quiet_cycles >= WATCHDOG_LIMIT && (pending_reqs.size() != 0 || in_valid ||
					expected_draws.size() != 0)) begin
				$display("timeout after %0d quiet cycles", quiet_cycles);
				$display("entropy_mixing_random_source: mismatch");
				$finish;
			end
		end
	end

	initial begin
		int ph;
		logic [31:0] mults[5];
		entropy_model = ENTROPY_RESET;
		shuffle_model = SHUFFLE_RESET;
		mults = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'h9E37_79B9, 32'd3};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: every width and mode, extremes, empty and inverted ranges
		for (int ws = 0; ws < 4; ws++) begin
			queue_req(1'b0, 2'(ws), 1'b0, '0, '0, '0);
			queue_req(1'b0, 2'(ws), 1'b1, '1, '1, '1);
			queue_req(1'b1, 2'(ws), 1'b0, '0, '1, 64'd5);
			queue_req(1'b1, 2'(ws), 1'b1, 64'h8000_0000_8000_8080, 64'h7FFF_FFFF_7FFF_7F7F,
				64'd9);
			queue_req(1'b1, 2'(ws), ws[0], 64'd7, 64'd7, '0);
		end
		queue_req(1'b1, WS_8, 1'b1, 64'h10, 64'h90, 64'd1);
		queue_req(1'b1, WS_64, 1'b0, '1, '0, 64'd2);
		wait_idle();
		for (ph = 0; ph < 5; ph++) begin
			write_shuffle(mults[ph]);
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 51; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 51; end
				default: begin send_idle_pct = 19; recv_stall_pct = 19; end
			endcase
			for (int i = 0; i < 385; i++)
				queue_req(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
					1'($urandom_range(0, 1)), edge_val(), edge_val(), rand64());
			wait_idle();
		end
		$display("covered %0d draws over five multiplier settings and four idling mixes", sent);
		$display("results checked: %0d, errors: %0d", received, errors);
		if (errors == 0 && expected_draws.size() == 0)
			$display("entropy_mixing_random_source: match");
		else
			$display("entropy_mixing_random_source: mismatch");
		$finish;
	end
endmodule
